@@ sv/rcol_pkg.sv @@
// Shared types and constants of the ready-slot round-robin collector.
`default_nettype none

package rcol_pkg;

   localparam int FIRST_CLIENT_SLOT = 1;

   typedef logic [2:0] op_type;
   typedef logic [5:0] slot_type;
   typedef logic [5:0] limit_type;
   typedef logic [5:0] cap_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_ALLOC     = 3'd0;
   localparam op_type OP_RELEASE   = 3'd1;
   localparam op_type OP_ARM       = 3'd2;
   localparam op_type OP_DISARM    = 3'd3;
   localparam op_type OP_SET_READY = 3'd4;
   localparam op_type OP_SCAN      = 3'd5;

   localparam status_type STATUS_DONE = 2'd0;
   localparam status_type STATUS_FULL = 2'd1;
   localparam status_type STATUS_NONE = 2'd2;

   localparam cap_type GRANT_CAP_RESET = 6'd32;

   typedef struct packed {
      op_type    op;
      slot_type  slot;
      logic      ready_bit;
      limit_type limit;
   } req_type;

   typedef struct packed {
      status_type status;
      slot_type   granted_slot;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic in_use;
      logic armed;
      logic ready;
   } entry_type;

endpackage

`default_nettype wire

@@ sv/rcol_if.sv @@
// Request and response channel interfaces of the ready-slot collector.
`default_nettype none

interface rcol_req_if;
   import rcol_pkg::*;
   logic      valid;
   logic      ready;
   op_type    op;
   slot_type  slot;
   logic      ready_bit;
   limit_type limit;

   modport source (output valid, output op, output slot, output ready_bit,
                   output limit, input ready);
   modport sink (input valid, input op, input slot, input ready_bit,
                 input limit, output ready);
endinterface

interface rcol_rsp_if;
   import rcol_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   slot_type   granted_slot;
   logic       last;

   modport source (output valid, output status, output granted_slot,
                   output last, input ready);
   modport sink (input valid, input status, input granted_slot, input last,
                 output ready);
endinterface

`default_nettype wire

@@ sv/rcol_flag_ram.sv @@
// Slot flag memory with one write port and one registered read port.
`default_nettype none

module rcol_flag_ram
   import rcol_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire entry_type       wr_data,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output entry_type            rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/rcol_seq.sv @@
// Sequencer; searches and scans read one slot entry per cycle unless stalled.
`default_nettype none

module rcol_seq
   import rcol_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int MAX_GRANTS = 32,
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req,
   input  wire cap_type       grant_cap,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output entry_type          ram_wdata,
   output logic               ram_re,
   output logic [AW-1:0]      ram_raddr,
   input  wire entry_type     ram_rdata,
   output logic               res_valid,
   output rsp_type            res,
   input  wire logic          out_free
);

   localparam int GW = $clog2(MAX_GRANTS + 1);

   typedef logic [AW-1:0] addr_type;
   typedef logic [AW:0]   cnt_type;
   typedef logic [GW-1:0] lim_type;

   localparam cnt_type     SLOTS_CNT = cnt_type'(SLOTS);
   localparam cnt_type     LAST_CNT = cnt_type'(SLOTS - 1);
   localparam cnt_type     FIRST_CNT = cnt_type'(FIRST_CLIENT_SLOT);
   localparam logic [6:0]  MAX_GRANTS_W = 7'(MAX_GRANTS);
   localparam rsp_type     RSP_DONE = '{status: STATUS_DONE, granted_slot: '0, last: 1'b1};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_CHECK,
      ST_REL_SEARCH,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   cnt_type   addr_ff, addr_in;
   logic      pend_ff, pend_in;
   addr_type  pend_addr_ff, pend_addr_in;
   op_type    op_ff, op_in;
   addr_type  slot_ff, slot_in;
   logic      ready_bit_ff, ready_bit_in;
   addr_type  hu_ff, hu_in;
   cnt_type   ptr_ff, ptr_in;
   addr_type  visits_ff, visits_in;
   lim_type   lim_ff, lim_in;
   lim_type   count_ff, count_in;
   logic      hold_valid_ff, hold_valid_in;
   addr_type  hold_slot_ff, hold_slot_in;
   logic      stop_ff, stop_in;
   rsp_type   res_ff, res_in;

   logic       slot_ok;
   limit_type  lim_req;
   cap_type    cap_eff;
   logic [6:0] lim_min;
   logic       grant;
   logic       stall;
   logic       hit;
   lim_type    count_next;
   cnt_type    idx;
   entry_type  entry_mod;

   always_comb begin
      slot_ok = (req.slot >= slot_type'(FIRST_CLIENT_SLOT)) && (int'(req.slot) < SLOTS);
      lim_req = (req.limit == '0) ? limit_type'(1) : req.limit;
      cap_eff = (grant_cap == '0) ? cap_type'(1) : grant_cap;
      lim_min = {1'b0, (cap_eff < lim_req) ? cap_eff : lim_req};
      if (lim_min > MAX_GRANTS_W) begin
         lim_min = MAX_GRANTS_W;
      end
      grant = pend_ff && (pend_addr_ff != '0) && ram_rdata.armed && ram_rdata.ready &&
              ram_rdata.in_use;
      stall = grant && hold_valid_ff && !out_free;
      count_next = count_ff + lim_type'(1);
      hit = grant && (count_next == lim_ff);
      idx = (ptr_ff > {1'b0, hu_ff}) ? FIRST_CNT : ptr_ff;
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      pend_in = pend_ff;
      pend_addr_in = pend_addr_ff;
      op_in = op_ff;
      slot_in = slot_ff;
      ready_bit_in = ready_bit_ff;
      hu_in = hu_ff;
      ptr_in = ptr_ff;
      visits_in = visits_ff;
      lim_in = lim_ff;
      count_in = count_ff;
      hold_valid_in = hold_valid_ff;
      hold_slot_in = hold_slot_ff;
      stop_in = stop_ff;
      res_in = res_ff;
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re = 1'b0;
      ram_raddr = '0;
      res_valid = 1'b0;
      res = res_ff;
      entry_mod = ram_rdata;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = addr_ff[AW-1:0];
            addr_in = addr_ff + cnt_type'(1);
            if (addr_ff == LAST_CNT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req.op;
               slot_in = addr_type'(req.slot);
               ready_bit_in = req.ready_bit;
               pend_in = 1'b0;
               stop_in = 1'b0;
               hold_valid_in = 1'b0;
               count_in = '0;
               lim_in = lim_type'(lim_min);
               visits_in = hu_ff;
               res_in = RSP_DONE;
               unique case (req.op) inside
                  OP_ALLOC: begin
                     addr_in = FIRST_CNT;
                     state_in = ST_ALLOC;
                  end
                  OP_RELEASE, OP_ARM, OP_DISARM, OP_SET_READY: begin
                     if (slot_ok) begin
                        ram_re = 1'b1;
                        ram_raddr = addr_type'(req.slot);
                        state_in = ST_CHECK;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  OP_SCAN: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            if (pend_ff && !ram_rdata.in_use) begin
               ram_we = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = '{in_use: 1'b1, armed: 1'b0, ready: 1'b0};
               if (pend_addr_ff > hu_ff) begin
                  hu_in = pend_addr_ff;
               end
               pend_in = 1'b0;
               res_in = '{status: STATUS_DONE, granted_slot: slot_type'(pend_addr_ff),
                          last: 1'b1};
               state_in = ST_EMIT;
            end else if (addr_ff < SLOTS_CNT) begin
               ram_re = 1'b1;
               ram_raddr = addr_ff[AW-1:0];
               pend_in = 1'b1;
               pend_addr_in = addr_ff[AW-1:0];
               addr_in = addr_ff + cnt_type'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               res_in = '{status: STATUS_FULL, granted_slot: '0, last: 1'b1};
               state_in = ST_EMIT;
            end
         end
         ST_CHECK: begin
            state_in = ST_EMIT;
            if (ram_rdata.in_use) begin
               ram_we = 1'b1;
               ram_waddr = slot_ff;
               unique case (op_ff)
                  OP_RELEASE: begin
                     entry_mod = '0;
                     if (slot_ff == hu_ff) begin
                        addr_in = {1'b0, slot_ff} - cnt_type'(1);
                        state_in = ST_REL_SEARCH;
                     end
                  end
                  OP_ARM: entry_mod.armed = 1'b1;
                  OP_DISARM: entry_mod.armed = 1'b0;
                  OP_SET_READY: entry_mod.ready = ready_bit_ff;
                  default: entry_mod = ram_rdata;
               endcase
               ram_wdata = entry_mod;
            end
         end
         ST_REL_SEARCH: begin
            if (pend_ff && ram_rdata.in_use) begin
               hu_in = pend_addr_ff;
               pend_in = 1'b0;
               state_in = ST_EMIT;
            end else if (addr_ff != '0) begin
               ram_re = 1'b1;
               ram_raddr = addr_ff[AW-1:0];
               pend_in = 1'b1;
               pend_addr_in = addr_ff[AW-1:0];
               addr_in = addr_ff - cnt_type'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               hu_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (stop_ff || ((visits_ff == '0) && !pend_ff)) begin
               if (hold_valid_ff) begin
                  res_in = '{status: STATUS_DONE, granted_slot: slot_type'(hold_slot_ff),
                             last: 1'b1};
               end else begin
                  res_in = '{status: STATUS_NONE, granted_slot: '0, last: 1'b1};
               end
               state_in = ST_EMIT;
            end else if (!stall) begin
               pend_in = 1'b0;
               if (grant) begin
                  entry_mod.armed = 1'b0;
                  ram_we = 1'b1;
                  ram_waddr = pend_addr_ff;
                  ram_wdata = entry_mod;
                  if (hold_valid_ff) begin
                     res_valid = 1'b1;
                     res = '{status: STATUS_DONE, granted_slot: slot_type'(hold_slot_ff),
                             last: 1'b0};
                  end
                  hold_valid_in = 1'b1;
                  hold_slot_in = pend_addr_ff;
                  count_in = count_next;
                  stop_in = hit;
               end
               if (!hit && (visits_ff != '0)) begin
                  ram_re = 1'b1;
                  ram_raddr = idx[AW-1:0];
                  ptr_in = idx + cnt_type'(1);
                  visits_in = visits_ff - addr_type'(1);
                  pend_in = 1'b1;
                  pend_addr_in = idx[AW-1:0];
               end
            end
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            res = res_ff;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         pend_ff <= 1'b0;
         hu_ff <= '0;
         ptr_ff <= '0;
         hold_valid_ff <= 1'b0;
         stop_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         pend_ff <= pend_in;
         hu_ff <= hu_in;
         ptr_ff <= ptr_in;
         hold_valid_ff <= hold_valid_in;
         stop_ff <= stop_in;
         count_ff <= count_in;
      end
      pend_addr_ff <= pend_addr_in;
      op_ff <= op_in;
      slot_ff <= slot_in;
      ready_bit_ff <= ready_bit_in;
      visits_ff <= visits_in;
      lim_ff <= lim_in;
      hold_slot_ff <= hold_slot_in;
      res_ff <= res_in;
   end

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("Slot memory written while no item is in progress.");

   a_no_same_slot_rw: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("Slot memory read and written at the same slot in one cycle.");

   a_count_within_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff <= lim_ff))
      else $error("Scan gave more grants than its limit.");

   a_item_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("Accepted item did not start any work.");

endmodule

`default_nettype wire

@@ sv/ready_slot_round_robin_collector_core.sv @@
// Top level of the ready-slot round-robin collector with its register and output stage.
// Allocate, and release of the highest-used slot, walk the slot memory one entry per cycle.
// A scan visits highest_used slots and pauses while the response side stalls.
// One item is in progress at a time; req ready is low from acceptance to the last response.
// After reset a clearing pass zeroes every slot memory entry before req ready rises.
// Reset also sets grant_cap to 32 and clears the scan pointer and highest-used mark.
`default_nettype none

module ready_slot_round_robin_collector_core
   import rcol_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int MAX_GRANTS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_enable,
   input  wire cap_type csr_write_data,
   rcol_req_if.sink     req_ch,
   rcol_rsp_if.source   rsp_ch
);

   localparam int AW = $clog2(SLOTS);

   cap_type         grant_cap_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;
   req_type         req;
   logic            req_ready;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   entry_type       ram_wdata;
   logic            ram_re;
   logic [AW-1:0]   ram_raddr;
   entry_type       ram_rdata;
   logic            res_valid;
   rsp_type         res;
   logic            out_free;

   assign req = '{op: req_ch.op, slot: req_ch.slot, ready_bit: req_ch.ready_bit,
                  limit: req_ch.limit};
   assign req_ch.ready = req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grant_cap_ff <= GRANT_CAP_RESET;
      end else if (csr_write_enable) begin
         grant_cap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && out_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.granted_slot = rsp_ff.granted_slot;
   assign rsp_ch.last = rsp_ff.last;

   rcol_seq #(
      .SLOTS(SLOTS),
      .MAX_GRANTS(MAX_GRANTS),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ready),
      .req(req),
      .grant_cap(grant_cap_ff),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_re(ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .res_valid(res_valid),
      .res(res),
      .out_free(out_free)
   );

   rcol_flag_ram #(
      .DEPTH(SLOTS),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en(ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the ready-slot round-robin collector core.
`default_nettype none

module tb;
   import rcol_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 64;
   localparam int MAX_GRANTS = 32;
   localparam op_type OP_SPARE_6 = 3'd6;
   localparam op_type OP_SPARE_7 = 3'd7;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_write_enable;
   cap_type csr_write_data;

   rcol_req_if req_ch ();
   rcol_rsp_if rsp_ch ();

   ready_slot_round_robin_collector_core #(
      .SLOTS(SLOTS),
      .MAX_GRANTS(MAX_GRANTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   bit [SLOTS-1:0] in_use_map = '0;
   bit [SLOTS-1:0] armed_map = '0;
   bit [SLOTS-1:0] ready_map = '0;
   int unsigned    scan_ptr = 0;
   int unsigned    high_used = 0;
   cap_type        grant_cap_now = GRANT_CAP_RESET;

   rsp_type awaited_rsp[$];
   int      fail_count = 0;
   bit      send_idle_on = 1'b1;
   bit      rsp_idle_on = 1'b1;
   int      long_hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Works out the results of one accepted item and advances the slot table.
   task automatic slot_table_step(input op_type op, input slot_type s, input logic rb,
                                  input limit_type lim);
      rsp_type     res;
      rsp_type     held;
      bit          have_held;
      bit          client_ok;
      bit          found;
      bit          stop;
      int unsigned want;
      int unsigned cap_eff;
      int unsigned granted;
      int unsigned visits;
      int unsigned idx;
      int unsigned h;
      client_ok = (s >= FIRST_CLIENT_SLOT) && in_use_map[s];
      res.status = STATUS_DONE;
      res.granted_slot = '0;
      res.last = 1'b1;
      case (op)
         OP_ALLOC: begin
            found = 1'b0;
            for (int i = FIRST_CLIENT_SLOT; i < SLOTS; i++) begin
               if (!found && !in_use_map[i]) begin
                  found = 1'b1;
                  in_use_map[i] = 1'b1;
                  if (i > high_used) high_used = i;
                  res.granted_slot = slot_type'(i);
               end
            end
            if (!found) res.status = STATUS_FULL;
            awaited_rsp.push_back(res);
         end
         OP_RELEASE: begin
            if (client_ok) begin
               in_use_map[s] = 1'b0;
               armed_map[s] = 1'b0;
               ready_map[s] = 1'b0;
               if (s == high_used) begin
                  h = 0;
                  for (int i = high_used; i > 0; i--) begin
                     if (h == 0 && in_use_map[i]) h = i;
                  end
                  high_used = h;
               end
            end
            awaited_rsp.push_back(res);
         end
         OP_ARM: begin
            if (client_ok) armed_map[s] = 1'b1;
            awaited_rsp.push_back(res);
         end
         OP_DISARM: begin
            if (client_ok) armed_map[s] = 1'b0;
            awaited_rsp.push_back(res);
         end
         OP_SET_READY: begin
            if (client_ok) ready_map[s] = rb;
            awaited_rsp.push_back(res);
         end
         OP_SCAN: begin
            want = (lim == 0) ? 1 : lim;
            cap_eff = (grant_cap_now == 0) ? 1 : grant_cap_now;
            if (cap_eff < want) want = cap_eff;
            if (MAX_GRANTS < want) want = MAX_GRANTS;
            visits = high_used;
            granted = 0;
            stop = 1'b0;
            have_held = 1'b0;
            for (int v = 0; v < visits; v++) begin
               if (!stop) begin
                  if (scan_ptr > high_used) scan_ptr = FIRST_CLIENT_SLOT;
                  idx = scan_ptr;
                  scan_ptr++;
                  if (idx >= FIRST_CLIENT_SLOT && idx < SLOTS && armed_map[idx] &&
                      ready_map[idx] && in_use_map[idx]) begin
                     armed_map[idx] = 1'b0;
                     if (have_held) awaited_rsp.push_back(held);
                     held.status = STATUS_DONE;
                     held.granted_slot = slot_type'(idx);
                     held.last = 1'b0;
                     have_held = 1'b1;
                     granted++;
                     if (granted >= want) stop = 1'b1;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               awaited_rsp.push_back(held);
            end else begin
               res.status = STATUS_NONE;
               awaited_rsp.push_back(res);
            end
         end
         default: begin
            awaited_rsp.push_back(res);
         end
      endcase
   endtask

   task automatic send_item(input op_type op, input slot_type s, input logic rb,
                            input limit_type lim);
      int unsigned gap;
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.slot <= s;
      req_ch.ready_bit <= rb;
      req_ch.limit <= lim;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      slot_table_step(op, s, rb, lim);
   endtask

   task automatic wait_for_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0 || req_ch.ready !== 1'b1);
   endtask

   task automatic write_grant_cap(input cap_type value);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      grant_cap_now = value;
   endtask

   function automatic slot_type pick_slot();
      int unsigned used[$];
      for (int i = FIRST_CLIENT_SLOT; i < SLOTS; i++) begin
         if (in_use_map[i]) used.push_back(i);
      end
      if (used.size() != 0 && $urandom_range(0, 9) < 8) begin
         return slot_type'(used[$urandom_range(0, used.size() - 1)]);
      end
      return slot_type'($urandom_range(0, SLOTS - 1));
   endfunction

   task automatic test_directed_ops();
      send_item(OP_SCAN, '0, 1'b0, '0);
      send_item(OP_ARM, 6'd1, 1'b0, '0);
      send_item(OP_SET_READY, 6'd0, 1'b1, '0);
      send_item(OP_RELEASE, 6'd63, 1'b0, '0);
      send_item(OP_SPARE_6, 6'd63, 1'b1, 6'd63);
      send_item(OP_SPARE_7, 6'd63, 1'b1, 6'd63);
      send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_ARM, 6'd0, 1'b0, '0);
      send_item(OP_ARM, 6'd2, 1'b0, '0);
      send_item(OP_SET_READY, 6'd2, 1'b1, '0);
      send_item(OP_ARM, 6'd3, 1'b0, '0);
      send_item(OP_SET_READY, 6'd3, 1'b1, '0);
      send_item(OP_SCAN, '0, 1'b0, 6'd0);
      send_item(OP_SCAN, '0, 1'b0, 6'd63);
      send_item(OP_ARM, 6'd2, 1'b0, '0);
      send_item(OP_SET_READY, 6'd2, 1'b0, '0);
      send_item(OP_SCAN, '0, 1'b0, 6'd1);
      send_item(OP_DISARM, 6'd2, 1'b0, '0);
      send_item(OP_RELEASE, 6'd3, 1'b0, '0);
      send_item(OP_RELEASE, 6'd1, 1'b0, '0);
      send_item(OP_RELEASE, 6'd2, 1'b0, '0);
      send_item(OP_SCAN, '0, 1'b0, 6'd32);
      send_item(OP_ALLOC, '0, 1'b0, '0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < SLOTS - 1; i++) send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_RELEASE, 6'd5, 1'b0, '0);
      send_item(OP_ALLOC, '0, 1'b0, '0);
   endtask

   task automatic test_grant_limits();
      write_grant_cap(6'd63);
      for (int i = 1; i <= 6; i++) begin
         send_item(OP_ARM, slot_type'(i), 1'b0, '0);
         send_item(OP_SET_READY, slot_type'(i), 1'b1, '0);
      end
      send_item(OP_SCAN, '0, 1'b0, 6'd2);
      send_item(OP_SCAN, '0, 1'b0, 6'd0);
      write_grant_cap(6'd1);
      send_item(OP_SCAN, '0, 1'b0, 6'd32);
      write_grant_cap(6'd0);
      send_item(OP_SCAN, '0, 1'b0, 6'd9);
      write_grant_cap(6'd63);
      send_item(OP_SCAN, '0, 1'b0, 6'd63);
   endtask

   task automatic test_release_shuffled();
      int order[SLOTS-1];
      int j;
      int t;
      for (int i = 0; i < SLOTS - 1; i++) order[i] = i + 1;
      for (int i = SLOTS - 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < 20; i++) begin
         send_item(OP_RELEASE, slot_type'(order[i]), 1'b0, '0);
      end
      send_item(OP_SCAN, '0, 1'b0, 6'd63);
   endtask

   task automatic test_output_backpressure();
      wait_for_idle();
      send_idle_on = 1'b0;
      long_hold_cycles = 200;
      send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_ALLOC, '0, 1'b0, '0);
      send_item(OP_ARM, 6'd1, 1'b0, '0);
      send_item(OP_SET_READY, 6'd1, 1'b1, '0);
      send_item(OP_SCAN, '0, 1'b0, 6'd4);
      send_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int unsigned n_items, input bit idling);
      int unsigned r;
      op_type      op;
      limit_type   lim;
      send_idle_on = idling;
      rsp_idle_on = idling;
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(0, 99);
         lim = ($urandom_range(0, 3) == 0) ? limit_type'($urandom_range(0, 63))
                                           : limit_type'($urandom_range(0, 8));
         if (r < 20) op = OP_ALLOC;
         else if (r < 32) op = OP_RELEASE;
         else if (r < 52) op = OP_ARM;
         else if (r < 58) op = OP_DISARM;
         else if (r < 78) op = OP_SET_READY;
         else if (r < 95) op = OP_SCAN;
         else op = op_type'($urandom_range(0, 7));
         if (r < 95) begin
            send_item(op, pick_slot(), logic'($urandom_range(0, 3) != 0), lim);
         end else begin
            send_item(op, slot_type'($urandom_range(0, 63)), logic'($urandom_range(0, 1)),
                      limit_type'($urandom_range(0, 63)));
         end
      end
   endtask

   initial begin : rsp_ready_driver
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles > 0) begin
            n = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected item: status %0d slot %0d last %0d", $time,
                     rsp_ch.status, rsp_ch.granted_slot, rsp_ch.last);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.granted_slot !== want.granted_slot ||
                rsp_ch.last !== want.last) begin
               $display("%0t: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                        $time, want.status, want.granted_slot, want.last,
                        rsp_ch.status, rsp_ch.granted_slot, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   initial begin : main_sequence
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_ALLOC;
      req_ch.slot <= '0;
      req_ch.ready_bit <= 1'b0;
      req_ch.limit <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= GRANT_CAP_RESET;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_grant_cap(6'd32);
      test_directed_ops();
      test_table_full();
      test_grant_limits();
      write_grant_cap(6'd32);
      test_release_shuffled();
      test_output_backpressure();
      test_random_traffic(10, 1'b1);
      write_grant_cap(cap_type'($urandom_range(2, 31)));
      test_random_traffic(8, 1'b1);
      write_grant_cap(6'd1);
      test_random_traffic(6, 1'b1);
      write_grant_cap(6'd63);
      test_random_traffic(10, 1'b0);
      wait_for_idle();
      repeat (SLOTS + 8) @(posedge clock);
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
